@@ hdl/mrrc_pkg.sv @@
`default_nettype none

package mrrc_pkg;

  // Frame delimiters of a modem response.
  localparam logic [7:0] RESP_START = 8'h3E;
  localparam logic [7:0] RESP_END   = 8'h3B;

  // Shortest response that carries start, command, CRC and end bytes.
  localparam logic [7:0] MIN_FRAME_LEN = 8'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 2'd1;

  // Input function codes.
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // One input beat.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  // Input stage as seen by the checking core.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // Configuration register values.
  typedef struct packed {
    logic [7:0] expected_length;
    logic [7:0] expected_command;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic       stored;
    logic [5:0] byte_index;
    logic       complete;
    logic       response_ok;
    logic [5:0] received_length;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/mrrc_rx_if.sv @@
`default_nettype none

interface mrrc_rx_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/mrrc_rsp_if.sv @@
`default_nettype none

interface mrrc_rsp_if;
  logic       valid;
  logic       ready;
  logic       stored;
  logic [5:0] byte_index;
  logic       complete;
  logic       response_ok;
  logic [5:0] received_length;

  modport source (output valid, output stored, output byte_index, output complete,
                  output response_ok, output received_length, input ready);
  modport sink   (input valid, input stored, input byte_index, input complete,
                  input response_ok, input received_length, output ready);
endinterface

`default_nettype wire

@@ hdl/mrrc_cfg_if.sv @@
`default_nettype none

interface mrrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/modem_response_receive_check.sv @@
`default_nettype none
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------------
// rx       in   func (0 byte, 1 restart), rx_byte
// rsp      out  stored, byte_index, complete, response_ok, received_length
// cfg      in   index (0 expected_length, 1 expected_command), data
//
// One rx beat gives one rsp beat; a beat can be taken every cycle while rsp is not stalled.
// An input register holds each beat, then the CRC-16/ARC byte update
// and checks feed the result register.
// rst is synchronous and active high; it clears the capture and sets
// expected_length to 5 and expected_command to 0.
// A stalled rsp holds its beat while one more rx beat waits; cfg is always ready.

module modem_response_receive_check #(
  parameter int unsigned BUFFER_BYTES = 48
) (
  input wire logic  clk,
  input wire logic  rst,
  mrrc_rx_if.sink   rx,
  mrrc_rsp_if.source rsp,
  mrrc_cfg_if.sink  cfg
);
  import mrrc_pkg::*;

  cfg_t    cfg_regs;
  item_t   in_item;
  stage_t  stage;
  logic    take;
  result_t result;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.expected_length  <= 8'd5;
      cfg_regs.expected_command <= 8'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_EXPECTED_LENGTH:  cfg_regs.expected_length  <= cfg.data;
        CFG_EXPECTED_COMMAND: cfg_regs.expected_command <= cfg.data;
        default: ;
      endcase
    end
  end

  assign in_item.func    = rx.func;
  assign in_item.rx_byte = rx.rx_byte;

  mrrc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .in_item  (in_item),
    .stage    (stage),
    .take     (take)
  );

  mrrc_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .take      (take),
    .cfg       (cfg_regs),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .result    (result)
  );

  assign rsp.stored          = result.stored;
  assign rsp.byte_index      = result.byte_index;
  assign rsp.complete        = result.complete;
  assign rsp.response_ok     = result.response_ok;
  assign rsp.received_length = result.received_length;

endmodule

`default_nettype wire

@@ hdl/mrrc_in_reg.sv @@
`default_nettype none

module mrrc_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mrrc_pkg::item_t in_item,
  output mrrc_pkg::stage_t     stage,
  input  wire logic            take
);
  import mrrc_pkg::*;

  logic  valid;
  item_t item;

  // The register refills in the same cycle the core takes its beat.
  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

`default_nettype wire

@@ hdl/mrrc_core.sv @@
`default_nettype none

module mrrc_core #(
  parameter int unsigned BUFFER_BYTES = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mrrc_pkg::stage_t stage,
  output logic                  take,
  input  wire mrrc_pkg::cfg_t   cfg,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mrrc_pkg::result_t     result
);
  import mrrc_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(BUFFER_BYTES);

  // CRC-16/ARC update by one byte, LSB first.
  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  logic [CW-1:0] byte_count,   byte_count_next;
  logic [15:0]   running_crc,  running_crc_next;
  logic [15:0]   received_crc, received_crc_next;
  logic          checks_passed, checks_passed_next;
  logic          capture_done, capture_done_next;
  logic [7:0]    last_byte,    last_byte_next;
  result_t       result_next;

  logic [7:0] idx8;
  logic [7:0] count8_next;
  logic       stored;
  logic       dropped_idle;
  logic       finish;
  logic       ok;

  // The output register frees up when it is empty or being read.
  assign take = !out_valid || out_ready;

  // Capture state update for the beat in the input register.
  always_comb begin
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    checks_passed_next = checks_passed;
    capture_done_next  = capture_done;
    last_byte_next     = last_byte;
    stored             = 1'b0;
    dropped_idle       = 1'b0;
    finish             = 1'b0;
    idx8               = 8'(byte_count);

    if (stage.item.func == FUNC_RESTART) begin
      byte_count_next    = '0;
      running_crc_next   = '0;
      received_crc_next  = '0;
      checks_passed_next = 1'b1;
      last_byte_next     = '0;
      capture_done_next  = (cfg.expected_length == 8'd0);
    end else if (!capture_done) begin
      if (byte_count == '0 && stage.item.rx_byte != RESP_START) begin
        // Line noise before the frame starts.
        dropped_idle = 1'b1;
      end else if (byte_count < FULL_COUNT) begin
        stored = 1'b1;
        if (idx8 == 8'd1 && stage.item.rx_byte != cfg.expected_command) begin
          checks_passed_next = 1'b0;
        end
        // Place the byte: CRC-covered body, CRC high, or CRC low.
        if (cfg.expected_length >= MIN_FRAME_LEN) begin
          if (idx8 >= 8'd1 && idx8 <= cfg.expected_length - 8'd4) begin
            running_crc_next = crc_arc_byte(running_crc, stage.item.rx_byte);
          end else if (idx8 == cfg.expected_length - 8'd3) begin
            received_crc_next = {stage.item.rx_byte, received_crc[7:0]};
          end else if (idx8 == cfg.expected_length - 8'd2) begin
            received_crc_next = {received_crc[15:8], stage.item.rx_byte};
          end
        end
        last_byte_next  = stage.item.rx_byte;
        byte_count_next = byte_count + CW'(1);
      end else begin
        // Buffer overflow ends the capture.
        finish = 1'b1;
      end
      if (!dropped_idle && 8'(byte_count_next) == cfg.expected_length) begin
        finish = 1'b1;
      end
      if (finish) begin
        capture_done_next = 1'b1;
      end
    end
  end

  // Verdict on the updated state.
  assign count8_next = 8'(byte_count_next);
  always_comb begin
    if (cfg.expected_length == 8'd0) begin
      ok = 1'b1;
    end else begin
      ok = checks_passed_next && cfg.expected_length >= MIN_FRAME_LEN &&
           count8_next == cfg.expected_length && last_byte_next == RESP_END &&
           running_crc_next == received_crc_next;
    end
  end

  always_comb begin
    result_next.stored          = stored;
    result_next.byte_index      = stored ? idx8[5:0] : 6'd0;
    result_next.complete        = capture_done_next;
    result_next.response_ok     = capture_done_next && ok;
    result_next.received_length = count8_next[5:0];
  end

  // Capture state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      running_crc   <= '0;
      received_crc  <= '0;
      checks_passed <= 1'b1;
      capture_done  <= 1'b0;
      last_byte     <= '0;
    end else if (take && stage.valid) begin
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      checks_passed <= checks_passed_next;
      capture_done  <= capture_done_next;
      last_byte     <= last_byte_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage.valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mrrc_checker.sv @@
`default_nettype none

module mrrc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       rsp_stored,
  input wire logic [5:0] rsp_byte_index,
  input wire logic       rsp_complete,
  input wire logic       rsp_response_ok,
  input wire logic [5:0] rsp_received_length
);

  // A verdict is only reported once the capture has finished.
  a_ok_needs_complete: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_response_ok |-> rsp_complete)
    else $error("response_ok without complete");

  // The input side stalls only behind a result that waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled with no waiting result");

  // A stored byte sits just below the reported length.
  a_index_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stored |-> rsp_received_length == rsp_byte_index + 6'd1)
    else $error("byte_index does not match received_length");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_received_length) &&
    $stable(rsp_complete) && $stable(rsp_response_ok))
    else $error("stalled result changed");

endmodule

bind modem_response_receive_check mrrc_checker u_mrrc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .rx_ready            (rx.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_stored          (rsp.stored),
  .rsp_byte_index      (rsp.byte_index),
  .rsp_complete        (rsp.complete),
  .rsp_response_ok     (rsp.response_ok),
  .rsp_received_length (rsp.received_length)
);

`default_nettype wire
